@@ rtl/core/cc_pkg.sv @@
`timescale 1ns / 1ps
// cc_pkg: shared types, constants and quarter-round helpers for the chacha20 core
// no dependencies; imported by every other file in rtl/core

package cc_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned STATE_WORDS = 16;
  localparam int unsigned BLOCK_BYTES = 64;
  localparam int unsigned BLOCK_BITS  = STATE_WORDS * WORD_W;
  localparam int unsigned USED_W      = $clog2(BLOCK_BYTES);
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 64;

  // 10 double rounds, each two half quarter-rounds on columns then on diagonals
  localparam int unsigned ROUND_STEPS = 40;
  localparam int unsigned STEP_W      = $clog2(ROUND_STEPS);

  localparam logic [WORD_W-1:0] SIGMA0 = 32'h6170_7865;
  localparam logic [WORD_W-1:0] SIGMA1 = 32'h3320_646E;
  localparam logic [WORD_W-1:0] SIGMA2 = 32'h7962_2D32;
  localparam logic [WORD_W-1:0] SIGMA3 = 32'h6B20_6574;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LO = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_HI = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_CTR = 3'd6;

  typedef logic [WORD_W-1:0] word_t;
  typedef word_t [STATE_WORDS-1:0] state_t;

  typedef struct packed {
    logic [63:0] key0;
    logic [63:0] key1;
    logic [63:0] key2;
    logic [63:0] key3;
    logic [63:0] nonce_lo;
    word_t       nonce_hi;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              start;
  } item_t;

  // back -> block engine
  typedef struct packed {
    logic  kick;
    logic  abort;
    logic  take;
    word_t ctr;
  } blk_cmd_t;

  // block engine -> back
  typedef struct packed {
    logic  idle;
    logic  done;
    word_t ctr;
  } blk_stat_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
  } qr_t;

  // first half uses rotations 16/12, second half 8/7
  function automatic qr_t qr_half(word_t a, word_t b, word_t c, word_t d, logic second);
    qr_t   r;
    word_t a1;
    word_t b1;
    word_t c1;
    word_t d1;
    a1 = a + b;
    d1 = d ^ a1;
    d1 = second ? {d1[23:0], d1[31:24]} : {d1[15:0], d1[31:16]};
    c1 = c + d1;
    b1 = b ^ c1;
    b1 = second ? {b1[24:0], b1[31:25]} : {b1[19:0], b1[31:20]};
    r.a = a1;
    r.b = b1;
    r.c = c1;
    r.d = d1;
    return r;
  endfunction

  function automatic state_t init_state(cfg_t cfg, word_t ctr);
    state_t s;
    s[0]  = SIGMA0;
    s[1]  = SIGMA1;
    s[2]  = SIGMA2;
    s[3]  = SIGMA3;
    s[4]  = cfg.key0[31:0];
    s[5]  = cfg.key0[63:32];
    s[6]  = cfg.key1[31:0];
    s[7]  = cfg.key1[63:32];
    s[8]  = cfg.key2[31:0];
    s[9]  = cfg.key2[63:32];
    s[10] = cfg.key3[31:0];
    s[11] = cfg.key3[63:32];
    s[12] = ctr;
    s[13] = cfg.nonce_lo[31:0];
    s[14] = cfg.nonce_lo[63:32];
    s[15] = cfg.nonce_hi;
    return s;
  endfunction

endpackage

@@ rtl/core/cc_ifs.sv @@
`timescale 1ns / 1ps
// cc_in_if / cc_out_if: valid/ready channels for the chacha20 core
// depends on cc_pkg

interface cc_in_if import cc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              message_start;

  modport source (output valid, data_byte, message_start, input ready);
  modport sink   (input valid, data_byte, message_start, output ready);
endinterface

interface cc_out_if import cc_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] result_byte;

  modport source (output valid, result_byte, input ready);
  modport sink   (input valid, result_byte, output ready);
endinterface

@@ rtl/core/cc_front.sv @@
`timescale 1ns / 1ps
// cc_front: input side, takes byte transfers, tags message starts, queues them
// depends on cc_pkg and cc_in_if

module cc_front import cc_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic     clk,
  input  logic     rst,
  cc_in_if.sink    in_chan,
  output item_t    head,
  output logic     head_valid,
  input  logic     pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t           queue [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  logic            do_pop;
  item_t           item_in;

  assign in_chan.ready = (count != CW'(DEPTH));
  assign push          = in_chan.valid && in_chan.ready;
  assign head_valid    = (count != '0);
  assign do_pop        = pop && head_valid;
  assign head          = queue[rd_ptr];

  always_comb begin
    item_in.data  = in_chan.data_byte;
    item_in.start = in_chan.message_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= item_in;
    end
  end

endmodule

@@ rtl/core/cc_block.sv @@
`timescale 1ns / 1ps
// cc_block: iterative block function, two dependent adds per lane per cycle
// depends on cc_pkg

module cc_block import cc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  blk_cmd_t  cmd,
  output blk_stat_t stat,
  output state_t    block
);

  typedef enum logic [1:0] {IDLE, RUN, FEED, DONE} blk_state_t;

  blk_state_t        state;
  logic [STEP_W-1:0] step;
  state_t            x;
  word_t             ctr;
  state_t            rnd;
  state_t            fed;
  state_t            s;
  logic              diag;
  logic              half;

  assign diag = step[1];
  assign half = step[0];
  assign s    = init_state(cfg, ctr);

  // four half quarter-rounds in parallel, on columns or diagonals
  always_comb begin
    logic [3:0] ib;
    logic [3:0] ic;
    logic [3:0] id;
    qr_t        q;
    rnd = x;
    for (int i = 0; i < 4; i++) begin
      ib = diag ? 4'(4 + ((i + 1) % 4))  : 4'(4 + i);
      ic = diag ? 4'(8 + ((i + 2) % 4))  : 4'(8 + i);
      id = diag ? 4'(12 + ((i + 3) % 4)) : 4'(12 + i);
      q  = qr_half(x[i], x[ib], x[ic], x[id], half);
      rnd[i]  = q.a;
      rnd[ib] = q.b;
      rnd[ic] = q.c;
      rnd[id] = q.d;
    end
  end

  always_comb begin
    for (int i = 0; i < STATE_WORDS; i++) begin
      fed[i] = x[i] + s[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      step  <= '0;
    end else if (cmd.abort) begin
      state <= IDLE;
    end else begin
      unique case (state)
        IDLE: begin
          if (cmd.kick) begin
            state <= RUN;
            step  <= '0;
            ctr   <= cmd.ctr;
            x     <= init_state(cfg, cmd.ctr);
          end
        end
        RUN: begin
          x    <= rnd;
          step <= step + 1'b1;
          if (step == STEP_W'(ROUND_STEPS - 1)) begin
            state <= FEED;
          end
        end
        FEED: begin
          x     <= fed;
          state <= DONE;
        end
        DONE: begin
          if (cmd.take) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign stat.idle = (state == IDLE);
  assign stat.done = (state == DONE);
  assign stat.ctr  = ctr;
  assign block     = x;

endmodule

@@ rtl/core/cc_back.sv @@
`timescale 1ns / 1ps
// cc_back: keystream buffer, block prefetch control, xor and output register
// depends on cc_pkg and cc_out_if

module cc_back import cc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  item_t     head,
  input  logic      head_valid,
  output logic      pop,
  input  logic      cfg_we,
  input  word_t     init_ctr,
  output blk_cmd_t  cmd,
  input  blk_stat_t stat,
  input  state_t    block,
  cc_out_if.source  out_chan
);

  logic [BLOCK_BITS-1:0] bank;
  logic                  bank_valid;
  logic [USED_W-1:0]     used;
  logic                  start_done;
  word_t                 gen_ctr;
  logic                  out_valid;
  logic [BYTE_W-1:0]     out_byte;

  logic                  out_free;
  logic                  apply_start;
  logic                  consume;
  logic                  last;
  logic                  take;
  logic                  abort;
  logic                  kick;
  logic [BYTE_W-1:0]     ks_byte;

  assign out_free    = !out_valid || out_chan.ready;
  assign apply_start = head_valid && head.start && !start_done;
  assign consume     = head_valid && !apply_start && bank_valid && out_free;
  assign last        = consume && (used == USED_W'(BLOCK_BYTES - 1));
  assign take        = stat.done && !apply_start && !cfg_we && (!bank_valid || last);
  assign abort       = apply_start || cfg_we;
  assign kick        = stat.idle && !abort;
  assign ks_byte     = bank[{used, 3'b000} +: BYTE_W];
  assign pop         = consume;

  assign cmd.kick  = kick;
  assign cmd.abort = abort;
  assign cmd.take  = take;
  assign cmd.ctr   = gen_ctr;

  assign out_chan.valid       = out_valid;
  assign out_chan.result_byte = out_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_valid <= 1'b0;
      used       <= '0;
      start_done <= 1'b0;
      gen_ctr    <= '0;
      out_valid  <= 1'b0;
    end else begin
      // next block counter for the engine
      priority if (apply_start) begin
        gen_ctr <= init_ctr;
      end else if (cfg_we && !stat.idle) begin
        gen_ctr <= stat.ctr;
      end else if (kick) begin
        gen_ctr <= gen_ctr + 1'b1;
      end

      priority if (apply_start) begin
        bank_valid <= 1'b0;
      end else if (take) begin
        bank_valid <= 1'b1;
        used       <= '0;
      end else if (last) begin
        bank_valid <= 1'b0;
      end else if (consume) begin
        used <= used + 1'b1;
      end

      if (apply_start) begin
        start_done <= 1'b1;
      end else if (consume) begin
        start_done <= 1'b0;
      end

      if (consume) begin
        out_valid <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      bank <= block;
    end
    if (consume) begin
      out_byte <= head.data ^ ks_byte;
    end
  end

endmodule

@@ rtl/core/chacha20_stream_cipher.sv @@
`timescale 1ns / 1ps
// chacha20_stream_cipher: top level, byte-wide chacha20 encrypt/decrypt core
// depends on cc_pkg, cc_ifs, cc_front, cc_block, cc_back
//
//  port       | dir  | transfer / write                 | payload
//  -----------+------+----------------------------------+--------------------------------
//  in_chan    | sink | valid && ready                   | data_byte[7:0], message_start
//  out_chan   | src  | valid && ready                   | result_byte[7:0]
//  cfg_*      | in   | cfg_we (no wait, no read-back)   | cfg_index[2:0], cfg_data[63:0]
//
//  sustained rate is one byte per cycle while out_chan is ready; the block
//  engine makes a 64-byte block in one kick, 40 half quarter-round steps, one
//  feed-forward and one handoff, and runs one block ahead of the byte stream
//  a byte with message_start stalls the queue head while the first block for
//  the reloaded counter is made
//  a config write drops the prefetched block and restarts it with new values
//  reset is synchronous; no clearing pass, the keystream bank starts empty
//  in_chan stays ready while the input queue has room, even when out_chan stalls

module chacha20_stream_cipher import cc_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  cc_in_if.sink                 in_chan,
  cc_out_if.source              out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration registers
  cfg_t      cfg;
  word_t     init_ctr;

  // front to back queue head
  item_t     head;
  logic      head_valid;
  logic      pop;

  // back to block engine
  blk_cmd_t  cmd;
  blk_stat_t stat;
  state_t    block;

  // register writes; an index beyond the list is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg      <= '0;
      init_ctr <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY0:     cfg.key0     <= cfg_data;
        CFG_KEY1:     cfg.key1     <= cfg_data;
        CFG_KEY2:     cfg.key2     <= cfg_data;
        CFG_KEY3:     cfg.key3     <= cfg_data;
        CFG_NONCE_LO: cfg.nonce_lo <= cfg_data;
        CFG_NONCE_HI: cfg.nonce_hi <= cfg_data[WORD_W-1:0];
        CFG_INIT_CTR: init_ctr     <= cfg_data[WORD_W-1:0];
        default: ;
      endcase
    end
  end

  // input queue, decouples byte arrival from keystream availability
  cc_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_chan    (in_chan),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop)
  );

  // block function, computes the next keystream block in the background
  cc_block u_block (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .cmd   (cmd),
    .stat  (stat),
    .block (block)
  );

  // keystream bank, counter tracking and output register
  cc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .cfg_we     (cfg_we),
    .init_ctr   (init_ctr),
    .cmd        (cmd),
    .stat       (stat),
    .block      (block),
    .out_chan   (out_chan)
  );

endmodule

@@ verif/cc_tb_pkg.sv @@
`timescale 1ns / 1ps
// cc_tb_pkg: chacha20 keystream predictor and result-byte checker used by tb_top
// depends on cc_pkg for widths, sigma constants and register indexes

package cc_tb_pkg;
  import cc_pkg::*;

  class cipher_checker;
    logic [63:0]       key [4];
    logic [63:0]       nonce_lo;
    word_t             nonce_hi;
    word_t             ctr_init;
    word_t             block_ctr;
    logic [BYTE_W-1:0] ks [BLOCK_BYTES];
    int unsigned       used;
    word_t             w [STATE_WORDS];
    logic [BYTE_W-1:0] expected_bytes [$];
    int unsigned       errors;
    int unsigned       bytes_in;
    int unsigned       results_ok;
    int unsigned       starts;
    int unsigned       blocks;
    int unsigned       wraps;

    function new();
      foreach (key[i]) key[i] = '0;
      foreach (ks[i]) ks[i] = '0;
      nonce_lo   = '0;
      nonce_hi   = '0;
      ctr_init   = '0;
      block_ctr  = '0;
      used       = BLOCK_BYTES;
      errors     = 0;
      bytes_in   = 0;
      results_ok = 0;
      starts     = 0;
      blocks     = 0;
      wraps      = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_KEY0:     key[0] = val;
        CFG_KEY1:     key[1] = val;
        CFG_KEY2:     key[2] = val;
        CFG_KEY3:     key[3] = val;
        CFG_NONCE_LO: nonce_lo = val;
        CFG_NONCE_HI: nonce_hi = val[WORD_W-1:0];
        CFG_INIT_CTR: ctr_init = val[WORD_W-1:0];
        default: ;
      endcase
    endfunction

    static function word_t rotl(word_t v, int unsigned n);
      return (v << n) | (v >> (WORD_W - n));
    endfunction

    function void mix(int a, int b, int c, int d);
      w[a] += w[b]; w[d] = rotl(w[d] ^ w[a], 16);
      w[c] += w[d]; w[b] = rotl(w[b] ^ w[c], 12);
      w[a] += w[b]; w[d] = rotl(w[d] ^ w[a], 8);
      w[c] += w[d]; w[b] = rotl(w[b] ^ w[c], 7);
    endfunction

    // 20 rounds over the current key, nonce and counter, then feed-forward
    function void make_keystream_block();
      word_t s [STATE_WORDS];
      word_t k;
      s[0] = SIGMA0;
      s[1] = SIGMA1;
      s[2] = SIGMA2;
      s[3] = SIGMA3;
      for (int i = 0; i < 4; i++) begin
        s[4 + 2 * i] = key[i][31:0];
        s[5 + 2 * i] = key[i][63:32];
      end
      s[12] = block_ctr;
      s[13] = nonce_lo[31:0];
      s[14] = nonce_lo[63:32];
      s[15] = nonce_hi;
      w = s;
      repeat (10) begin
        mix(0, 4, 8, 12);
        mix(1, 5, 9, 13);
        mix(2, 6, 10, 14);
        mix(3, 7, 11, 15);
        mix(0, 5, 10, 15);
        mix(1, 6, 11, 12);
        mix(2, 7, 8, 13);
        mix(3, 4, 9, 14);
      end
      for (int i = 0; i < STATE_WORDS; i++) begin
        k = w[i] + s[i];
        ks[4 * i]     = k[7:0];
        ks[4 * i + 1] = k[15:8];
        ks[4 * i + 2] = k[23:16];
        ks[4 * i + 3] = k[31:24];
      end
      if (block_ctr == '1) wraps++;
      block_ctr++;
      blocks++;
    endfunction

    function void take_plain(logic [BYTE_W-1:0] d, logic st);
      bytes_in++;
      if (st) begin
        starts++;
        block_ctr = ctr_init;
        used      = BLOCK_BYTES;
      end
      if (used >= BLOCK_BYTES) begin
        make_keystream_block();
        used = 0;
      end
      expected_bytes.push_back(d ^ ks[used]);
      used++;
    endfunction

    function void check_cipher(logic [BYTE_W-1:0] r);
      logic [BYTE_W-1:0] want;
      if (expected_bytes.size() == 0) begin
        errors++;
        $error("result_byte with nothing expected: actual %02h", r);
        return;
      end
      want = expected_bytes.pop_front();
      if (r !== want) begin
        errors++;
        $error("result_byte mismatch: expected %02h, actual %02h", want, r);
      end else begin
        results_ok++;
      end
    endfunction

    function int unsigned pending();
      return expected_bytes.size();
    endfunction
  endclass

endpackage

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps
// tb_top: byte-stream test of chacha20_stream_cipher against a keystream predictor
// depends on cc_pkg, cc_ifs, the rtl core and verif/cc_tb_pkg

module tb_top;
  import cc_pkg::*;
  import cc_tb_pkg::*;

  // cycles with no transfer and no write before the run is called hung;
  // worst honest gap is a start stall plus a receiver hold chain
  localparam int unsigned IDLE_LIMIT  = 2000;
  // idle wait after the final drain, before the summary is printed
  localparam int unsigned TAIL_CYCLES = 64;
  // index past the register list, must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_GAPPY, RX_HOLD} rx_mode_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  cc_in_if  in_chan ();
  cc_out_if out_chan ();

  cipher_checker chk;
  int unsigned   burst_left  = 0;
  int unsigned   idle_cycles = 0;
  int unsigned   settings    = 0;

  chacha20_stream_cipher i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // observe transfers and writes at the edge; input is noted before the
  // result so a same-edge pair still lines up in order
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) chk.write_reg(cfg_index, cfg_data);
      if (in_chan.valid && in_chan.ready) begin
        chk.take_plain(in_chan.data_byte, in_chan.message_start);
      end
      if (out_chan.valid && out_chan.ready) chk.check_cipher(out_chan.result_byte);
    end
  end

  // watchdog: any transfer or register write counts as progress
  always @(posedge clk) begin
    if (rst || cfg_we || (in_chan.valid && in_chan.ready) ||
        (out_chan.valid && out_chan.ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  // receiver: stretches of always-ready, coin-flip, regular gaps and hard holds
  initial begin
    rx_mode_t    mode;
    int unsigned len;
    out_chan.ready = 1'b0;
    forever begin
      mode = rx_mode_t'($urandom_range(0, 3));
      len  = (mode == RX_HOLD) ? $urandom_range(1, 30) : $urandom_range(1, 80);
      for (int unsigned k = 0; k < len; k++) begin
        @(posedge clk);
        case (mode)
          RX_OPEN:  out_chan.ready <= 1'b1;
          RX_COIN:  out_chan.ready <= 1'($urandom_range(0, 1));
          RX_GAPPY: out_chan.ready <= (k % 4 != 3);
          default:  out_chan.ready <= 1'b0;
        endcase
      end
    end
  end

  // one byte transfer; the sender runs in bursts with random gaps between
  task automatic send_byte(input logic [BYTE_W-1:0] d, input logic st);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_chan.valid         <= 1'b1;
    in_chan.data_byte     <= d;
    in_chan.message_start <= st;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  // stop sending and wait for every predicted byte to come back
  task automatic drain();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (chk.pending() != 0);
  endtask

  // cfg_we stays high across back-to-back writes; close_writes drops it
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic close_writes();
    cfg_we <= 1'b0;
    settings++;
  endtask

  // message body: random bytes with some all-zero (raw keystream) and all-one
  // bytes, plus rare restarts inside the stream
  task automatic run_stream(input int unsigned n, input logic first_start);
    logic              st;
    logic [BYTE_W-1:0] d;
    for (int unsigned i = 0; i < n; i++) begin
      st = (i == 0) ? first_start : ($urandom_range(0, 119) == 0);
      case ($urandom_range(0, 7))
        0:       d = '0;
        1:       d = '1;
        default: d = BYTE_W'($urandom);
      endcase
      send_byte(d, st);
    end
  endtask

  // register value biased toward the extremes; counter values lean toward
  // the top so wraps show up often
  function automatic logic [CFG_DATA_W-1:0] pick_value(input int r);
    logic [CFG_DATA_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      default: v = {$urandom, $urandom};
    endcase
    if (r == CFG_INIT_CTR && $urandom_range(0, 2) == 0) begin
      v[31:0] = 32'hFFFF_FFFF - $urandom_range(0, 1);
    end
    return v;
  endfunction

  initial begin
    chk                   = new();
    rst                   = 1'b1;
    cfg_we                = 1'b0;
    cfg_index             = '0;
    cfg_data              = '0;
    in_chan.valid         = 1'b0;
    in_chan.data_byte     = '0;
    in_chan.message_start = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // all-zero registers straight out of reset, first byte without a start:
    // the empty buffer alone must trigger block 0
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hFE, 1'b0);
    send_byte(8'h7F, 1'b0);
    // restart in the middle of a block, then two starts in a row
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();

    // every register at all ones, counter at the top so the second block
    // of the message wraps to zero; the spare index must change nothing
    put_reg(CFG_KEY0, '1);
    put_reg(CFG_KEY1, '1);
    put_reg(CFG_KEY2, '1);
    put_reg(CFG_KEY3, '1);
    put_reg(CFG_NONCE_LO, '1);
    put_reg(CFG_NONCE_HI, '1);
    put_reg(CFG_INIT_CTR, '1);
    put_reg(CFG_SPARE, {$urandom, $urandom});
    close_writes();
    run_stream(200, 1'b1);
    drain();

    // published test key 00..1f, nonce with 0x4a in byte 7, counter 1
    put_reg(CFG_KEY0, 64'h0706_0504_0302_0100);
    put_reg(CFG_KEY1, 64'h0F0E_0D0C_0B0A_0908);
    put_reg(CFG_KEY2, 64'h1716_1514_1312_1110);
    put_reg(CFG_KEY3, 64'h1F1E_1D1C_1B1A_1918);
    put_reg(CFG_NONCE_LO, 64'h4A00_0000_0000_0000);
    put_reg(CFG_NONCE_HI, '0);
    put_reg(CFG_INIT_CTR, 64'd1);
    close_writes();
    run_stream(150, 1'b1);
    drain();

    // key change inside a message: leftover bytes keep the old key, the
    // next block made picks up the new one
    put_reg(CFG_KEY2, {$urandom, $urandom});
    close_writes();
    run_stream(90, 1'b0);
    drain();

    // random settings: each register written or left alone, messages that
    // sometimes continue across the write instead of restarting
    for (int p = 0; p < 9; p++) begin
      for (int r = CFG_KEY0; r <= CFG_INIT_CTR; r++) begin
        if ($urandom_range(0, 1) == 1) put_reg(CFG_IDX_W'(r), pick_value(r));
      end
      if ($urandom_range(0, 3) == 0) put_reg(CFG_SPARE, {$urandom, $urandom});
      close_writes();
      run_stream($urandom_range(100, 140), $urandom_range(0, 3) != 0);
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d bytes over %0d keystream blocks, %0d message starts, %0d counter wraps",
             chk.bytes_in, chk.blocks, chk.starts, chk.wraps);
    $display("%0d result bytes matched across %0d register settings",
             chk.results_ok, settings);
    if (chk.errors == 0 && chk.pending() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
